### rtl/first_fit_segment_allocator_top_defines.svh
// ----------------------------------------------------------------------------
// First-fit segment allocator assertion macros
// Shared concurrent check forms, clocked on clk_i, quiet during reset.
// ----------------------------------------------------------------------------
`ifndef FIRST_FIT_SEGMENT_ALLOCATOR_TOP_DEFINES_SVH
`define FIRST_FIT_SEGMENT_ALLOCATOR_TOP_DEFINES_SVH

// Property checked at every edge outside reset.
`define FFSA_ASSERT(lbl, prop) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) \
    else $error("ffsa assertion failed");

// Implication whose consequent is checked in the cycle after the antecedent.
`define FFSA_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("ffsa sequence check failed");

`endif

### rtl/ffsa_pkg.sv
// ----------------------------------------------------------------------------
// ffsa_pkg
// Types and constants of the first-fit segment allocator.
// ----------------------------------------------------------------------------
package ffsa_pkg;

  localparam int unsigned SZ_W   = 24;
  localparam int unsigned TEXT_W = 16;
  localparam int unsigned OIDX_W = 6;

  localparam logic [1:0] CFG_CHAR_BYTES   = 2'd0;
  localparam logic [1:0] CFG_RECORD_EXTRA = 2'd1;
  localparam logic [1:0] CFG_STORE_LIMIT  = 2'd2;

  localparam logic OP_ALLOC   = 1'b0;
  localparam logic OP_RELEASE = 1'b1;

  typedef enum logic [2:0] {
    ST_EXACT  = 3'd0,
    ST_SPLIT  = 3'd1,
    ST_APPEND = 3'd2,
    ST_TFULL  = 3'd3,
    ST_SFULL  = 3'd4,
    ST_BADREL = 3'd5
  } status_e;

  typedef struct packed {
    logic [SZ_W-1:0]   offset;
    logic [SZ_W-1:0]   size;
    logic [TEXT_W-1:0] text;
    logic              free;
  } seg_t;

endpackage

### rtl/ffsa_table.sv
// ----------------------------------------------------------------------------
// ffsa_table
// Segment table memory: one write port, one read port, registered read data.
// ----------------------------------------------------------------------------
module ffsa_table #(
  parameter int unsigned Depth = 64,
  parameter int unsigned AddrW = 6
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AddrW-1:0] waddr_i,
  input  ffsa_pkg::seg_t   wdata_i,
  input  logic [AddrW-1:0] raddr_i,
  output ffsa_pkg::seg_t   rdata_o
);

  ffsa_pkg::seg_t mem [Depth];
  ffsa_pkg::seg_t rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
    rdata_q <= mem[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

### rtl/first_fit_segment_allocator_top.sv
// ----------------------------------------------------------------------------
// first_fit_segment_allocator_top
// First-fit allocator over an ordered segment table, with split on oversize
// fit, append at the store end and release without merge.
// ----------------------------------------------------------------------------
//  channel  dir  signals                       content
//  s_axis   in   s_tvalid/s_tready/s_tdata     opcode, string_chars, release_index
//  m_axis   out  m_tvalid/m_tready/m_tdata     status, slot_index, slot_offset, slot_size
//  cfg      in   cfg_we/cfg_idx/cfg_data       char_bytes, record_extra, store_limit
//
//  Allocate: the scan reads up to all n table entries (n = table entries), one read per cycle.
//  A split adds the entry shift and two writes; a release checks the entry, then frees it.
//  Items go through the single table memory port pair one at a time.
//  Reset clears the counters, not the table; table entries are valid below the count.
//  A held result in the output register does not block the next transfer in.
// ----------------------------------------------------------------------------
`include "first_fit_segment_allocator_top_defines.svh"

module first_fit_segment_allocator_top #(
  parameter int unsigned TABLE_DEPTH = 64,
  parameter int unsigned MAX_CHARS   = 255
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_tvalid_i,
  output logic        s_tready_o,
  input  logic [15:0] s_tdata_i,   // opcode[0], string_chars[8:1], release_index[14:9]
  output logic        m_tvalid_o,
  input  logic        m_tready_i,
  output logic [63:0] m_tdata_o,   // status[2:0], slot_index[8:3], slot_offset[32:9],
                                   // slot_size[56:33]
  input  logic        cfg_we_i,
  input  logic [1:0]  cfg_idx_i,
  input  logic [23:0] cfg_data_i
);

  localparam int unsigned IW    = $clog2(TABLE_DEPTH);
  localparam int unsigned CW    = $clog2(TABLE_DEPTH + 1);
  localparam int unsigned CMP_W = (CW > 6) ? CW : 6;
  localparam int unsigned ChW   = $clog2(MAX_CHARS + 2);
  localparam int unsigned TxW   = ChW + 2;
  localparam int unsigned SZ_W  = ffsa_pkg::SZ_W;
  localparam int unsigned OW    = ffsa_pkg::OIDX_W;

  typedef enum logic [7:0] {
    S_IDLE     = 8'b0000_0001,
    S_SCAN     = 8'b0000_0010,
    S_SHIFT    = 8'b0000_0100,
    S_SPLIT_LO = 8'b0000_1000,
    S_SPLIT_HI = 8'b0001_0000,
    S_REL_CHK  = 8'b0010_0000,
    S_RESP     = 8'b0100_0000
  } state_e;

  state_e state_q, state_d;

  logic [1:0]      cb_q;
  logic [7:0]      extra_q;
  logic [SZ_W-1:0] limit_q;

  logic [CW-1:0]   used_q, used_d, free_q, free_d;
  logic [SZ_W-1:0] end_q, end_d;
  logic [CW-1:0]   n;

  logic [CW-1:0]   scan_q, scan_d, sh_q, sh_d;
  logic            chk_vld_q, chk_vld_d, wr_pend_q, wr_pend_d;
  logic [IW-1:0]   chk_idx_q, chk_idx_d, hit_idx_q, hit_idx_d, wr_addr_q, wr_addr_d;
  ffsa_pkg::seg_t  hit_q, hit_d;
  logic [SZ_W-1:0] need_q, need_d;
  logic [15:0]     text_q, text_d;

  ffsa_pkg::status_e res_st_q, res_st_d;
  logic [OW-1:0]     res_idx_q, res_idx_d;
  logic [SZ_W-1:0]   res_off_q, res_off_d, res_sz_q, res_sz_d;

  logic        m_tvalid_q;
  logic [63:0] m_tdata_q;

  logic            mem_we;
  logic [IW-1:0]   mem_wa, mem_ra;
  ffsa_pkg::seg_t  mem_wd, rd;

  logic            in_op;
  logic [7:0]      in_chars;
  logic [5:0]      in_rel;
  logic [16:0]     chars_w, chars_sat;
  logic [ChW-1:0]  chars_p1;
  logic [TxW-1:0]  text_full;
  logic [SZ_W:0]   end_sum;
  logic [SZ_W-1:0] rest;

  ffsa_table #(
    .Depth (TABLE_DEPTH),
    .AddrW (IW)
  ) u_table (
    .clk_i   (clk_i),
    .we_i    (mem_we),
    .waddr_i (mem_wa),
    .wdata_i (mem_wd),
    .raddr_i (mem_ra),
    .rdata_o (rd)
  );

  assign n          = used_q + free_q;
  assign s_tready_o = (state_q == S_IDLE);
  assign m_tvalid_o = m_tvalid_q;
  assign m_tdata_o  = m_tdata_q;

  assign in_op     = s_tdata_i[0];
  assign in_chars  = s_tdata_i[8:1];
  assign in_rel    = s_tdata_i[14:9];
  assign chars_w   = 17'(in_chars);
  assign chars_sat = (chars_w > 17'(MAX_CHARS)) ? 17'(MAX_CHARS) : chars_w;
  assign chars_p1  = ChW'(chars_sat) + ChW'(1);
  assign text_full = TxW'(cb_q) * TxW'(chars_p1);
  assign end_sum   = (SZ_W+1)'(end_q) + (SZ_W+1)'(need_q);
  assign rest      = hit_q.size - need_q;

  always_comb begin
    state_d   = state_q;
    used_d    = used_q;
    free_d    = free_q;
    end_d     = end_q;
    scan_d    = scan_q;
    sh_d      = sh_q;
    chk_vld_d = 1'b0;
    chk_idx_d = chk_idx_q;
    wr_pend_d = wr_pend_q;
    wr_addr_d = wr_addr_q;
    hit_idx_d = hit_idx_q;
    hit_d     = hit_q;
    need_d    = need_q;
    text_d    = text_q;
    res_st_d  = res_st_q;
    res_idx_d = res_idx_q;
    res_off_d = res_off_q;
    res_sz_d  = res_sz_q;
    mem_we    = 1'b0;
    mem_wa    = hit_idx_q;
    mem_wd    = hit_q;
    mem_ra    = scan_q[IW-1:0];

    unique case (state_q)
      S_IDLE: begin
        if (s_tvalid_i) begin
          if (in_op == ffsa_pkg::OP_RELEASE) begin
            if (CMP_W'(in_rel) >= CMP_W'(n)) begin
              res_st_d  = ffsa_pkg::ST_BADREL;
              res_idx_d = '0;
              res_off_d = '0;
              res_sz_d  = '0;
              state_d   = S_RESP;
            end else begin
              mem_ra    = IW'(in_rel);
              hit_idx_d = IW'(in_rel);
              state_d   = S_REL_CHK;
            end
          end else begin
            text_d  = 16'(text_full);
            need_d  = SZ_W'(text_full) + SZ_W'(extra_q);
            scan_d  = '0;
            state_d = S_SCAN;
          end
        end
      end

      S_SCAN: begin
        if (chk_vld_q && rd.free && (rd.size >= need_q)) begin
          if (rd.size == need_q) begin
            mem_we    = 1'b1;
            mem_wa    = chk_idx_q;
            mem_wd    = '{offset: rd.offset, size: rd.size, text: text_q, free: 1'b0};
            used_d    = used_q + CW'(1);
            free_d    = free_q - CW'(1);
            res_st_d  = ffsa_pkg::ST_EXACT;
            res_idx_d = OW'(chk_idx_q);
            res_off_d = rd.offset;
            res_sz_d  = need_q;
            state_d   = S_RESP;
          end else if (n >= CW'(TABLE_DEPTH)) begin
            res_st_d  = ffsa_pkg::ST_TFULL;
            res_idx_d = '0;
            res_off_d = '0;
            res_sz_d  = '0;
            state_d   = S_RESP;
          end else begin
            hit_idx_d = chk_idx_q;
            hit_d     = rd;
            sh_d      = n;
            wr_pend_d = 1'b0;
            state_d   = S_SHIFT;
          end
        end else if (scan_q < n) begin
          mem_ra    = scan_q[IW-1:0];
          chk_vld_d = 1'b1;
          chk_idx_d = scan_q[IW-1:0];
          scan_d    = scan_q + CW'(1);
        end else if (!chk_vld_q) begin
          state_d = S_RESP;
          if (n >= CW'(TABLE_DEPTH)) begin
            res_st_d  = ffsa_pkg::ST_TFULL;
            res_idx_d = '0;
            res_off_d = '0;
            res_sz_d  = '0;
          end else if (end_sum > (SZ_W+1)'(limit_q)) begin
            res_st_d  = ffsa_pkg::ST_SFULL;
            res_idx_d = '0;
            res_off_d = '0;
            res_sz_d  = '0;
          end else begin
            mem_we    = 1'b1;
            mem_wa    = n[IW-1:0];
            mem_wd    = '{offset: end_q, size: need_q, text: text_q, free: 1'b0};
            end_d     = end_sum[SZ_W-1:0];
            used_d    = used_q + CW'(1);
            res_st_d  = ffsa_pkg::ST_APPEND;
            res_idx_d = OW'(n);
            res_off_d = end_q;
            res_sz_d  = need_q;
          end
        end
      end

      S_SHIFT: begin
        if (wr_pend_q) begin
          mem_we = 1'b1;
          mem_wa = wr_addr_q;
          mem_wd = rd;
        end
        if (sh_q > (CW'(hit_idx_q) + CW'(1))) begin
          mem_ra    = IW'(sh_q - CW'(1));
          wr_pend_d = 1'b1;
          wr_addr_d = sh_q[IW-1:0];
          sh_d      = sh_q - CW'(1);
        end else begin
          wr_pend_d = 1'b0;
          if (!wr_pend_q) begin
            state_d = S_SPLIT_LO;
          end
        end
      end

      S_SPLIT_LO: begin
        mem_we    = 1'b1;
        mem_wa    = hit_idx_q;
        mem_wd    = '{offset: hit_q.offset, size: need_q, text: text_q, free: 1'b0};
        used_d    = used_q + CW'(1);
        res_st_d  = ffsa_pkg::ST_SPLIT;
        res_idx_d = OW'(hit_idx_q);
        res_off_d = hit_q.offset;
        res_sz_d  = need_q;
        state_d   = S_SPLIT_HI;
      end

      S_SPLIT_HI: begin
        mem_we  = 1'b1;
        mem_wa  = hit_idx_q + IW'(1);
        mem_wd  = '{offset: hit_q.offset + need_q, size: rest, text: rest[15:0], free: 1'b1};
        state_d = S_RESP;
      end

      S_REL_CHK: begin
        state_d = S_RESP;
        if (rd.free) begin
          res_st_d  = ffsa_pkg::ST_BADREL;
          res_idx_d = '0;
          res_off_d = '0;
          res_sz_d  = '0;
        end else begin
          mem_we    = 1'b1;
          mem_wa    = hit_idx_q;
          mem_wd    = '{offset: rd.offset, size: rd.size, text: rd.text, free: 1'b1};
          used_d    = used_q - CW'(1);
          free_d    = free_q + CW'(1);
          res_st_d  = ffsa_pkg::ST_EXACT;
          res_idx_d = OW'(hit_idx_q);
          res_off_d = rd.offset;
          res_sz_d  = rd.size;
        end
      end

      S_RESP: begin
        if (!m_tvalid_q || m_tready_i) begin
          state_d = S_IDLE;
        end
      end

      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q    <= S_IDLE;
      used_q     <= '0;
      free_q     <= '0;
      end_q      <= '0;
      chk_vld_q  <= 1'b0;
      wr_pend_q  <= 1'b0;
      m_tvalid_q <= 1'b0;
      cb_q       <= 2'd1;
      extra_q    <= 8'd8;
      limit_q    <= '1;
    end else begin
      state_q   <= state_d;
      used_q    <= used_d;
      free_q    <= free_d;
      end_q     <= end_d;
      chk_vld_q <= chk_vld_d;
      wr_pend_q <= wr_pend_d;
      if ((state_q == S_RESP) && (!m_tvalid_q || m_tready_i)) begin
        m_tvalid_q <= 1'b1;
      end else if (m_tready_i) begin
        m_tvalid_q <= 1'b0;
      end
      if (cfg_we_i) begin
        unique case (cfg_idx_i)
          ffsa_pkg::CFG_CHAR_BYTES:   cb_q    <= cfg_data_i[1:0];
          ffsa_pkg::CFG_RECORD_EXTRA: extra_q <= cfg_data_i[7:0];
          ffsa_pkg::CFG_STORE_LIMIT:  limit_q <= cfg_data_i;
          default: ;
        endcase
      end
    end
  end

  always_ff @(posedge clk_i) begin
    scan_q    <= scan_d;
    sh_q      <= sh_d;
    chk_idx_q <= chk_idx_d;
    wr_addr_q <= wr_addr_d;
    hit_idx_q <= hit_idx_d;
    hit_q     <= hit_d;
    need_q    <= need_d;
    text_q    <= text_d;
    res_st_q  <= res_st_d;
    res_idx_q <= res_idx_d;
    res_off_q <= res_off_d;
    res_sz_q  <= res_sz_d;
    if ((state_q == S_RESP) && (!m_tvalid_q || m_tready_i)) begin
      m_tdata_q <= {7'b0, res_sz_q, res_off_q, res_idx_q, res_st_q};
    end
  end

  `FFSA_ASSERT(a_count_bound, ((CW+1)'(used_q) + (CW+1)'(free_q)) <= (CW+1)'(TABLE_DEPTH))
  `FFSA_ASSERT(a_fail_zero, (m_tvalid_o && (m_tdata_o[2:0] >= ffsa_pkg::ST_TFULL)) |-> (m_tdata_o[56:3] == '0))
  `FFSA_ASSERT(a_shift_above_hit,
    ((state_q == S_SHIFT) && wr_pend_q) |-> (wr_addr_q > hit_idx_q + IW'(1)))
  `FFSA_ASSERT_NEXT(a_resp_loads,
    (state_q == S_RESP) && (!m_tvalid_q || m_tready_i), m_tvalid_o && (state_q == S_IDLE))

endmodule
